// ----- rtl/sfcd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types and constants for the stereo filtered clip distortion block.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    localparam int PIXEL_BITS_DEF = 12;

    typedef struct packed {
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] left_out;
        logic signed [31:0] right_out;
    } t_out_item;

    localparam logic [2:0] REG_HP_COEF  = 3'd0;
    localparam logic [2:0] REG_LP_COEF  = 3'd1;
    localparam logic [2:0] REG_DRIVE    = 3'd2;
    localparam logic [2:0] REG_TOP      = 3'd3;
    localparam logic [2:0] REG_BOTTOM   = 3'd4;
    localparam logic [2:0] REG_MODES    = 3'd5;
    localparam logic [2:0] REG_DRY      = 3'd6;
    localparam logic [2:0] REG_WET      = 3'd7;

    localparam logic [2:0] MODE_LIMIT    = 3'd0;
    localparam logic [2:0] MODE_ZERO     = 3'd1;
    localparam logic [2:0] MODE_RECTIFY  = 3'd2;
    localparam logic [2:0] MODE_PIXELATE = 3'd3;
    localparam logic [2:0] MODE_SATURATE = 3'd4;
    localparam logic [2:0] MODE_WRAP     = 3'd5;

    // divider request/response between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } t_div_rsp;

endpackage

// ----- rtl/sfcd_div.sv -----
// ----------------------------------------------------------------------------
// sfcd_div
// Unsigned 64/64 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfcd_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfcd_pkg::t_div_req  i_req,
    output sfcd_pkg::t_div_rsp  o_rsp
);

    logic [63:0] r_quo;
    logic [63:0] r_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] n_trial;
    logic [64:0] n_diff;

    always_comb begin
        n_trial = {r_rem, r_quo[63]};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quo  <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                if (!n_diff[64]) begin
                    r_rem <= n_diff[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= n_trial[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("divider did not start");
    a_cnt_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !i_req.start) |=> !r_busy) else $error("divider busy spurious");

endmodule

// ----- rtl/stereo_filtered_clip_distortion.sv -----
// ----------------------------------------------------------------------------
// stereo_filtered_clip_distortion
// Stereo highpass/lowpass, drive, clip shaping and dry/wet mix.
// ----------------------------------------------------------------------------
// One frame is processed at a time by a sequencer around a single shared
// signed multiplier and a bit-serial divider. A frame passes through the
// sequencer states, then waits in the output register until the receiver
// takes it; the next frame is accepted only once that register is empty.
// A wrap division runs the divider; a saturate division first forms its
// numerator on the shared multiplier. o_stall is high while the sequencer
// is busy and until the result has left the output register.
module stereo_filtered_clip_distortion #(
    parameter int PIXEL_BITS = sfcd_pkg::PIXEL_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  sfcd_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output sfcd_pkg::t_out_item  o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_H1A, S_H1B, S_H1C, S_H2A, S_H2B, S_H2C, S_L1A, S_L1B, S_L1C,
        S_L2A, S_L2B, S_L2C, S_DRV, S_DRVW, S_TOP, S_TOPW, S_BOT, S_BOTW,
        S_MIXA, S_MIXB, S_MIXC, S_NEXT, S_OUT, S_TOPM, S_BOTM
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_hp_coef, r_lp_coef;
    logic [22:0] r_drive;
    logic [17:0] r_top;
    logic signed [18:0] r_bottom;
    logic [5:0]  r_modes;
    logic [17:0] r_dry, r_wet;

    // filter state [channel][stage] : h1,h2,l1,l2
    logic signed [39:0] r_st [2][4];

    logic               r_ch;
    logic signed [15:0] r_x0, r_x1;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_f;
    logic signed [63:0] r_in;
    logic signed [31:0] r_y0;
    logic               r_ovalid;
    sfcd_pkg::t_out_item r_odata;

    // shared multiplier
    logic signed [40:0] n_ma;
    logic signed [23:0] n_mb;
    logic signed [64:0] n_prod;

    sfcd_pkg::t_div_req r_dreq;
    sfcd_pkg::t_div_rsp w_drsp;

    logic signed [15:0] w_x;
    logic signed [63:0] w_t, w_b, w_w, w_x256, w_nb;
    logic [2:0] w_mt, w_mb;
    logic [1:0] w_stg;
    logic signed [39:0] w_s;
    logic [15:0] w_c;
    logic signed [63:0] w_rnd, w_sat, w_pix, w_pix_src;
    logic [63:0] w_pmag;

    sfcd_div u_div (
        .i_clk (i_clk),
        .i_rst_n(i_rst_n),
        .i_req (r_dreq),
        .o_rsp (w_drsp)
    );

    assign w_x    = r_ch ? r_x1 : r_x0;
    assign w_x256 = 64'(w_x) <<< 8;
    assign w_t    = 64'(signed'({1'b0, r_top})) <<< 8;
    assign w_b    = (r_bottom > 0) ? 64'sd0 : (64'(r_bottom) <<< 8);
    // bottom magnitude in sample units
    assign w_nb   = -(w_b >>> 8);
    assign w_w    = w_t - w_b;
    assign w_mt   = r_modes[2:0];
    assign w_mb   = r_modes[5:3];

    always_comb begin
        case (r_state)
            S_H1A, S_H1B, S_H1C: w_stg = 2'd0;
            S_H2A, S_H2B, S_H2C: w_stg = 2'd1;
            S_L1A, S_L1B, S_L1C: w_stg = 2'd2;
            default:             w_stg = 2'd3;
        endcase
    end

    assign w_s = r_st[r_ch][w_stg];
    assign w_c = w_stg[1] ? r_lp_coef : r_hp_coef;

    always_comb begin
        case (r_state)
            S_H1A, S_H2A, S_L1A, S_L2A: begin
                n_ma = 41'(w_s);
                n_mb = 24'(signed'({1'b0, 17'd65536 - {1'b0, w_c}}));
            end
            S_H1B, S_H2B, S_L1B, S_L2B: begin
                n_ma = r_in[40:0];
                n_mb = 24'(signed'({1'b0, w_c}));
            end
            S_DRV: begin
                n_ma = 41'(r_st[r_ch][3]);
                n_mb = 24'(signed'({1'b0, r_drive}));
            end
            S_TOPM: begin
                n_ma = 41'(r_f - w_t);
                n_mb = 24'(signed'({1'b0, r_top}));
            end
            S_BOTM: begin
                n_ma = 41'(w_b - r_f);
                n_mb = 24'(w_nb);
            end
            S_MIXA: begin
                n_ma = 41'(w_x256);
                n_mb = 24'(signed'({1'b0, r_dry}));
            end
            default: begin
                n_ma = r_f[40:0];
                n_mb = 24'(signed'({1'b0, r_wet}));
            end
        endcase
        n_prod = 65'(n_ma * n_mb);
    end

    // rounding: (acc + 2^15) >>> 16, saturated to 40 bits
    always_comb begin
        w_rnd = (r_acc + 64'sd32768) >>> 16;
        if (w_rnd > 64'sh7F_FFFF_FFFF) w_sat = 64'sh7F_FFFF_FFFF;
        else if (w_rnd < -64'sh80_0000_0000) w_sat = -64'sh80_0000_0000;
        else w_sat = w_rnd;
    end

    // pixelate: trunc toward zero to integer, clear low bits
    always_comb begin
        w_pix_src = r_f;
        w_pmag = w_pix_src[63] ? (64'(-w_pix_src) >> 8) : (64'(w_pix_src) >> 8);
        w_pix = w_pix_src[63] ? -$signed(w_pmag) : $signed(w_pmag);
        w_pix = (w_pix & ~64'((64'd1 << PIXEL_BITS) - 64'd1)) <<< 8;
    end

    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_data      = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hp_coef <= 16'd655;
            r_lp_coef <= 16'd65470;
            r_drive   <= 23'd4096;
            r_top     <= 18'd155041;
            r_bottom  <= -19'sd155041;
            r_modes   <= '0;
            r_dry     <= 18'd4096;
            r_wet     <= 18'd4096;
            r_ovalid  <= 1'b0;
            r_ch      <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                for (int s = 0; s < 4; s++) begin
                    r_st[c][s] <= '0;
                end
            end
            r_dreq    <= '0;
        end else begin
            r_dreq.start <= 1'b0;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sfcd_pkg::REG_HP_COEF: r_hp_coef <= i_cfg_data[15:0];
                    sfcd_pkg::REG_LP_COEF: r_lp_coef <= i_cfg_data[15:0];
                    sfcd_pkg::REG_DRIVE:   r_drive   <= i_cfg_data[22:0];
                    sfcd_pkg::REG_TOP:     r_top     <= i_cfg_data[17:0];
                    sfcd_pkg::REG_BOTTOM:  r_bottom  <= i_cfg_data[18:0];
                    sfcd_pkg::REG_MODES:   r_modes   <= i_cfg_data[5:0];
                    sfcd_pkg::REG_DRY:     r_dry     <= i_cfg_data[17:0];
                    default:               r_wet     <= i_cfg_data[17:0];
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_x0    <= i_data.left_in;
                        r_x1    <= i_data.right_in;
                        r_ch    <= 1'b0;
                        r_state <= S_H1A;
                    end
                end
                S_H1A: begin
                    r_in <= w_x256;
                    r_acc <= n_prod[63:0];
                    r_state <= S_H1B;
                end
                S_H2A, S_L1A, S_L2A: begin
                    r_acc <= n_prod[63:0];
                    r_state <= t_state'(r_state + 5'd1);
                end
                S_H1B, S_H2B, S_L1B, S_L2B: begin
                    r_acc <= r_acc + n_prod[63:0];
                    r_state <= t_state'(r_state + 5'd1);
                end
                S_H1C, S_H2C, S_L1C, S_L2C: begin
                    r_st[r_ch][w_stg] <= w_sat[39:0];
                    case (r_state)
                        S_H1C: r_in <= w_sat;
                        S_H2C: r_in <= w_x256 - w_sat;
                        S_L1C: r_in <= w_sat;
                        default: r_in <= r_in;
                    endcase
                    r_state <= (r_state == S_L2C) ? S_DRV : t_state'(r_state + 5'd1);
                end
                S_DRV: begin
                    r_acc   <= n_prod[63:0];
                    r_state <= S_DRVW;
                end
                S_DRVW: begin
                    r_f     <= (r_acc + 64'sd2048) >>> 12;
                    r_state <= S_TOP;
                end
                S_TOP: begin
                    r_state <= S_BOT;
                    if (r_f > w_t) begin
                        case (w_mt)
                            sfcd_pkg::MODE_ZERO:     r_f <= '0;
                            sfcd_pkg::MODE_RECTIFY:  r_f <= (w_t <<< 1) - r_f;
                            sfcd_pkg::MODE_PIXELATE: r_f <= w_pix;
                            sfcd_pkg::MODE_SATURATE: r_state <= S_TOPM;
                            sfcd_pkg::MODE_WRAP: begin
                                if (w_w == 0) r_f <= w_t;
                                else begin
                                    r_dreq.start <= 1'b1;
                                    r_dreq.num   <= 64'(r_f - w_t);
                                    r_dreq.den   <= 64'(w_w <<< 1);
                                    r_state      <= S_TOPW;
                                end
                            end
                            default: r_f <= w_t;
                        endcase
                    end
                end
                // (f-T)*T formed as (f-T)*top_level on the shared multiplier, then x256
                S_TOPM: begin
                    r_dreq.start <= 1'b1;
                    r_dreq.num   <= n_prod[63:0] <<< 8;
                    r_dreq.den   <= 64'(r_f <<< 1);
                    r_state      <= S_TOPW;
                end
                S_TOPW: begin
                    if (w_drsp.done) begin
                        r_state <= S_BOT;
                        if (w_mt == sfcd_pkg::MODE_SATURATE)
                            r_f <= w_t + $signed(w_drsp.quo);
                        else if ($signed(w_drsp.rem) <= w_w)
                            r_f <= w_t - $signed(w_drsp.rem);
                        else
                            r_f <= w_b + ($signed(w_drsp.rem) - w_w);
                    end
                end
                S_BOT: begin
                    r_state <= S_MIXA;
                    if (r_f < w_b) begin
                        case (w_mb)
                            sfcd_pkg::MODE_ZERO:     r_f <= '0;
                            sfcd_pkg::MODE_RECTIFY:  r_f <= (w_b <<< 1) - r_f;
                            sfcd_pkg::MODE_PIXELATE: r_f <= w_pix;
                            sfcd_pkg::MODE_SATURATE: r_state <= S_BOTM;
                            sfcd_pkg::MODE_WRAP: begin
                                if (w_w == 0) r_f <= w_b;
                                else begin
                                    r_dreq.start <= 1'b1;
                                    r_dreq.num   <= 64'(w_b - r_f);
                                    r_dreq.den   <= 64'(w_w <<< 1);
                                    r_state      <= S_BOTW;
                                end
                            end
                            default: r_f <= w_b;
                        endcase
                    end
                end
                S_BOTM: begin
                    r_dreq.start <= 1'b1;
                    r_dreq.num   <= n_prod[63:0] <<< 8;
                    r_dreq.den   <= 64'((-r_f) <<< 1);
                    r_state      <= S_BOTW;
                end
                S_BOTW: begin
                    if (w_drsp.done) begin
                        r_state <= S_MIXA;
                        if (w_mb == sfcd_pkg::MODE_SATURATE)
                            r_f <= w_b - $signed(w_drsp.quo);
                        else if ($signed(w_drsp.rem) <= w_w)
                            r_f <= w_b + $signed(w_drsp.rem);
                        else
                            r_f <= w_t - ($signed(w_drsp.rem) - w_w);
                    end
                end
                S_MIXA: begin
                    r_acc   <= n_prod[63:0];
                    r_state <= S_MIXB;
                end
                S_MIXB: begin
                    r_acc   <= r_acc + n_prod[63:0];
                    r_state <= S_MIXC;
                end
                S_MIXC: begin
                    r_acc   <= (r_acc + 64'sd524288) >>> 20;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_acc > 64'sh7FFF_FFFF) r_in <= 64'sh7FFF_FFFF;
                    else if (r_acc < -64'sh8000_0000) r_in <= -64'sh8000_0000;
                    else r_in <= r_acc;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ch) begin
                        r_y0    <= r_in[31:0];
                        r_ch    <= 1'b1;
                        r_state <= S_H1A;
                    end else begin
                        r_odata.left_out  <= r_y0;
                        r_odata.right_out <= r_in[31:0];
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accepting while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_odata)))
        else $error("result lost under stall");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> (r_state == S_IDLE)) else $error("config while busy");

endmodule
